[rtl/sgsa_pkg.sv]
// ============================================================================
// sgsa_pkg: shared types and constants for the soft glyph slot allocator
// Register map, field widths, sequencer state encoding and reset values.
// ============================================================================
`default_nettype none

package sgsa_pkg;

    localparam int DefDisplayCols = 32;
    localparam int DefDisplayRows = 4;
    localparam int DefSlotCount   = 8;

    localparam logic [7:0] CellResetCode = 8'h20;

    localparam logic [2:0] RegColOffset = 3'd0;
    localparam logic [2:0] RegRowOffset = 3'd1;
    localparam logic [2:0] RegViewCols  = 3'd2;
    localparam logic [2:0] RegViewRows  = 3'd3;
    localparam logic [2:0] RegSlotsUsed = 3'd4;

    localparam logic KindWrite = 1'b0;
    localparam logic KindRead  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOKUP,
        ST_SEARCH,
        ST_DECIDE,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_COMMIT,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [7:0]  cell_code;
        logic        slot_defined;
        logic [2:0]  slot_number;
        logic [15:0] slot_glyph;
        logic        slot_evicted;
        logic        ignored;
    } result_t;

endpackage

`default_nettype wire

[rtl/soft_glyph_slot_allocator_top.sv]
// Sequence: a read or ignored item passes ST_READ and ST_OUT; a fixed write (priority 0)
//   adds ST_LOOKUP and ST_COMMIT; a soft write also runs the ST_SEARCH glyph match and the
//   ST_DECIDE free/least-priority search over the n usable slots, plus an ST_EVICT_RD /
//   ST_EVICT_CHK pass over every cell when a slot is evicted.
// Flow: one item in flight; the next transfer is accepted the cycle after the result transfer.
// Reset: registers to reset values; then a clearing pass writes 0x20 to every cell.
// ============================================================================
// soft_glyph_slot_allocator_top: character LCD glyph slot allocator
// Cell codes and fallbacks live in RAMs; slot table is a small register file.
// ============================================================================
`default_nettype none

module soft_glyph_slot_allocator_top #(
    parameter int DISPLAY_COLS = sgsa_pkg::DefDisplayCols,
    parameter int DISPLAY_ROWS = sgsa_pkg::DefDisplayRows,
    parameter int SLOT_COUNT   = sgsa_pkg::DefSlotCount
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // kind[0], cell_col[5:1], cell_row[7:6], glyph_id[23:8],
    // char_priority[31:24], fallback_code[39:32]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cell_code[7:0], slot_defined[8], slot_number[11:9], slot_glyph[27:12],
    // slot_evicted[28], ignored[29]
    output logic      [31:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import sgsa_pkg::*;

    localparam int CellCount = DISPLAY_COLS * DISPLAY_ROWS;
    localparam int CW = (CellCount > 1) ? $clog2(CellCount) : 1;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CCW = $clog2(CellCount + 1);

    // configuration
    logic [4:0] col_off_reg;
    logic [1:0] row_off_reg;
    logic [5:0] vcols_reg;
    logic [2:0] vrows_reg;
    logic [3:0] slots_reg;

    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_off_reg <= '0;
            row_off_reg <= '0;
            vcols_reg   <= 6'd32;
            vrows_reg   <= 3'd4;
            slots_reg   <= 4'd8;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                RegColOffset: col_off_reg <= pwdata[4:0];
                RegRowOffset: row_off_reg <= pwdata[1:0];
                RegViewCols:  vcols_reg   <= pwdata[5:0];
                RegViewRows:  vrows_reg   <= pwdata[2:0];
                RegSlotsUsed: slots_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            RegColOffset: prdata = {27'd0, col_off_reg};
            RegRowOffset: prdata = {30'd0, row_off_reg};
            RegViewCols:  prdata = {26'd0, vcols_reg};
            RegViewRows:  prdata = {29'd0, vrows_reg};
            RegSlotsUsed: prdata = {28'd0, slots_reg};
            default:      prdata = '0;
        endcase
    end

    // usable slot count, 0..SLOT_COUNT
    logic [4:0] n_slots;
    assign n_slots = (32'(slots_reg) < SLOT_COUNT) ? 5'(slots_reg) : 5'(SLOT_COUNT);

    // item registers
    logic        kind_reg;
    logic [CW-1:0] cell_reg;
    logic        outside_reg;
    logic [15:0] glyph_reg;
    logic [7:0]  prio_reg;
    logic [7:0]  fb_reg;

    // slot table
    logic [15:0] sg_reg [SLOT_COUNT];
    logic [7:0]  sp_reg [SLOT_COUNT];
    logic [7:0]  sr_reg [SLOT_COUNT];
    logic [SW-1:0] start_reg;

    // sequencer
    seq_state_t state_reg, state_next;
    logic [CCW-1:0] cnt_reg;
    logic [4:0] iter_reg;
    logic [SW-1:0] p_reg, least_reg, got_reg;
    logic [7:0] least_prio_reg;
    logic found_reg, got_ok_reg, evicted_reg, defined_reg;
    logic [7:0] old_reg;
    logic [CW-1:0] ev_addr_reg;
    result_t res_reg;
    logic m_valid_reg;

    // RAMs
    logic          code_we, fb_we;
    logic [CW-1:0] code_waddr, code_raddr;
    logic [7:0]    code_wdata, code_rdata, fb_rdata;

    sgsa_ram #(.WIDTH(8), .DEPTH(CellCount)) u_codes (
        .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
        .raddr(code_raddr), .rdata(code_rdata)
    );
    sgsa_ram #(.WIDTH(8), .DEPTH(CellCount)) u_fallbacks (
        .clk(clk), .we(fb_we), .waddr(cell_reg), .wdata(fb_reg),
        .raddr(code_raddr), .rdata(fb_rdata)
    );

    // input decode
    wire [5:0] in_acol = 6'(s_tdata[5:1]) + 6'(col_off_reg);
    wire [3:0] in_arow = 4'(s_tdata[7:6]) + 4'(row_off_reg);
    wire in_outside = (6'(s_tdata[5:1]) >= vcols_reg) || (3'(s_tdata[7:6]) >= vrows_reg)
                   || (32'(in_acol) >= DISPLAY_COLS) || (32'(in_arow) >= DISPLAY_ROWS);
    wire [CW-1:0] in_cell = CW'(32'(in_arow) * DISPLAY_COLS + 32'(in_acol));

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    wire in_xfer = s_tvalid && s_tready;
    wire out_xfer = m_tvalid && m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {2'b00, res_reg.ignored, res_reg.slot_evicted, res_reg.slot_glyph,
                      res_reg.slot_number, res_reg.slot_defined, res_reg.cell_code};

    // next slot in the rotating search
    wire [SW-1:0] p_inc = (5'(p_reg) + 5'd1 >= n_slots) ? '0 : SW'(5'(p_reg) + 5'd1);
    wire [SW-1:0] start_eff = (5'(start_reg) < n_slots) ? start_reg : '0;
    wire old_is_slot = (8'(n_slots) > old_reg);
    wire [SW-1:0] old_slot = SW'(old_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (32'(cnt_reg) == CellCount - 1) state_next = ST_IDLE;
            ST_IDLE:      if (in_xfer) state_next = ST_READ;
            ST_READ:
            begin
                if (outside_reg || kind_reg == KindRead) state_next = ST_OUT;
                else state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (prio_reg == 8'd0) state_next = ST_COMMIT;
                else state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (found_reg || n_slots == 5'd0) state_next = ST_COMMIT;
                else if (iter_reg == n_slots) state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // stay until a slot is claimed or the no-slot decision is made
                if (got_ok_reg)
                begin
                    if (evicted_reg) state_next = ST_EVICT_RD;
                    else state_next = ST_COMMIT;
                end
                else if (iter_reg > n_slots) state_next = ST_COMMIT;
            end
            ST_EVICT_RD:  state_next = ST_EVICT_CHK;
            ST_EVICT_CHK:
            begin
                if (32'(cnt_reg) == CellCount - 1) state_next = ST_COMMIT;
                else state_next = ST_EVICT_RD;
            end
            ST_COMMIT:    state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        code_we    = 1'b0;
        code_waddr = cell_reg;
        code_wdata = fb_reg;
        code_raddr = cell_reg;
        fb_we      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                code_we    = 1'b1;
                code_waddr = CW'(cnt_reg);
                code_wdata = CellResetCode;
            end
            // read the incoming cell so its code is ready in ST_READ
            ST_IDLE: code_raddr = in_cell;
            ST_EVICT_RD: code_raddr = CW'(cnt_reg);
            ST_EVICT_CHK:
            begin
                code_raddr = ev_addr_reg;
                code_we    = (code_rdata == 8'(got_reg));
                code_waddr = ev_addr_reg;
                code_wdata = fb_rdata;
            end
            ST_COMMIT:
            begin
                code_we    = 1'b1;
                code_wdata = got_ok_reg ? 8'(got_reg) : fb_reg;
                fb_we      = got_ok_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            start_reg      <= '0;
            kind_reg       <= 1'b0;
            cell_reg       <= '0;
            outside_reg    <= 1'b0;
            glyph_reg      <= '0;
            prio_reg       <= '0;
            fb_reg         <= '0;
            iter_reg       <= '0;
            p_reg          <= '0;
            least_reg      <= '0;
            got_reg        <= '0;
            least_prio_reg <= '0;
            found_reg      <= 1'b0;
            got_ok_reg     <= 1'b0;
            evicted_reg    <= 1'b0;
            defined_reg    <= 1'b0;
            old_reg        <= '0;
            ev_addr_reg    <= '0;
            res_reg        <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                sg_reg[i] <= '0;
                sp_reg[i] <= '0;
                sr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_xfer) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: cnt_reg <= cnt_reg + 1'b1;
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        kind_reg    <= s_tdata[0];
                        cell_reg    <= in_cell;
                        outside_reg <= in_outside;
                        glyph_reg   <= s_tdata[23:8];
                        prio_reg    <= s_tdata[31:24];
                        fb_reg      <= s_tdata[39:32];
                    end
                end
                ST_READ:
                begin
                    found_reg   <= 1'b0;
                    got_ok_reg  <= 1'b0;
                    evicted_reg <= 1'b0;
                    defined_reg <= 1'b0;
                    iter_reg    <= '0;
                    got_reg     <= '0;
                    res_reg.cell_code    <= (!outside_reg && kind_reg == KindRead)
                                            ? code_rdata : 8'd0;
                    res_reg.slot_defined <= 1'b0;
                    res_reg.slot_number  <= '0;
                    res_reg.slot_glyph   <= '0;
                    res_reg.slot_evicted <= 1'b0;
                    res_reg.ignored      <= outside_reg;
                    old_reg <= code_rdata;
                end
                ST_LOOKUP:
                begin
                    // release old reference
                    if (old_is_slot && sr_reg[old_slot] != 8'd0)
                        sr_reg[old_slot] <= sr_reg[old_slot] - 8'd1;
                    p_reg <= '0;
                end
                ST_SEARCH:
                begin
                    // phase 1: glyph match over slots 0..n-1, one a cycle
                    if (!found_reg && n_slots != 5'd0)
                    begin
                        if (iter_reg < n_slots)
                        begin
                            if (sg_reg[p_reg] == glyph_reg)
                            begin
                                found_reg  <= 1'b1;
                                got_ok_reg <= 1'b1;
                                got_reg    <= p_reg;
                            end
                            p_reg    <= p_inc;
                            iter_reg <= iter_reg + 5'd1;
                        end
                        else
                        begin
                            p_reg          <= start_eff;
                            least_reg      <= start_eff;
                            least_prio_reg <= sp_reg[start_eff];
                            iter_reg       <= '0;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    // phase 2: rotating free search / least priority, one a cycle
                    if (!got_ok_reg)
                    begin
                        if (iter_reg < n_slots)
                        begin
                            if (sr_reg[p_inc] == 8'd0)
                            begin
                                got_ok_reg  <= 1'b1;
                                got_reg     <= p_inc;
                                defined_reg <= 1'b1;
                                iter_reg    <= n_slots;
                            end
                            else
                            begin
                                if (sp_reg[p_inc] < least_prio_reg)
                                begin
                                    least_prio_reg <= sp_reg[p_inc];
                                    least_reg      <= p_inc;
                                end
                                iter_reg <= iter_reg + 5'd1;
                            end
                            p_reg <= p_inc;
                        end
                        else if (prio_reg > least_prio_reg)
                        begin
                            got_ok_reg  <= 1'b1;
                            got_reg     <= least_reg;
                            defined_reg <= 1'b1;
                            evicted_reg <= 1'b1;
                        end
                        else
                        begin
                            iter_reg <= iter_reg + 5'd1;
                        end
                    end
                    cnt_reg <= '0;
                end
                ST_EVICT_RD: ev_addr_reg <= CW'(cnt_reg);
                ST_EVICT_CHK: cnt_reg <= cnt_reg + 1'b1;
                ST_COMMIT:
                begin
                    if (got_ok_reg)
                    begin
                        if (defined_reg)
                        begin
                            sg_reg[got_reg] <= glyph_reg;
                            sp_reg[got_reg] <= prio_reg;
                            start_reg       <= got_reg;
                            res_reg.slot_defined <= 1'b1;
                            res_reg.slot_number  <= 3'(got_reg);
                            res_reg.slot_glyph   <= glyph_reg;
                            res_reg.slot_evicted <= evicted_reg;
                        end
                        if (evicted_reg) sr_reg[got_reg] <= 8'd1;
                        else if (sr_reg[got_reg] != 8'hff)
                            sr_reg[got_reg] <= sr_reg[got_reg] + 8'd1;
                        res_reg.cell_code <= 8'(got_reg);
                    end
                    else
                    begin
                        res_reg.cell_code <= fb_reg;
                    end
                end
                ST_OUT: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/sgsa_ram.sv]
// ============================================================================
// sgsa_ram: generic single-port-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module sgsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[tb/sv/tb_soft_glyph_slot_allocator_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_soft_glyph_slot_allocator_top: self-checking bench for the slot allocator
// Streams write/read items through several viewport and slot-count settings,
// predicts each result with a behavioral copy of the slot table and cell
// store, and checks every output transfer field by field in order.
// ============================================================================
`default_nettype none

module tb_soft_glyph_slot_allocator_top;
    import sgsa_pkg::*;

    localparam int NCOLS = 32;
    localparam int NROWS = 4;
    localparam int NSLOTS = 8;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [7:0]  cell_code;
        logic        slot_defined;
        logic [2:0]  slot_number;
        logic [15:0] slot_glyph;
        logic        slot_evicted;
        logic        ignored;
    } lcd_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    soft_glyph_slot_allocator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // model state
    logic [4:0]  cfg_col_off;
    logic [1:0]  cfg_row_off;
    logic [5:0]  cfg_cols;
    logic [2:0]  cfg_rows;
    logic [3:0]  cfg_slots;
    logic [7:0]  lcd_codes [NCELLS];
    logic [7:0]  lcd_fallbacks [NCELLS];
    bit          fallback_known [NCELLS];
    logic [15:0] slot_glyph_tbl [NSLOTS];
    logic [7:0]  slot_prio_tbl [NSLOTS];
    logic [7:0]  slot_refs [NSLOTS];
    int          rover;

    logic [39:0] item_q [$];
    lcd_result_t expected_q [$];
    int          err_count = 0;
    int          cycle_count = 0;

    // -1 when the cell lies outside the viewport or the display
    function automatic int cell_index(input logic [4:0] col, input logic [1:0] row);
        int acol;
        int arow;
        acol = int'(col) + int'(cfg_col_off);
        arow = int'(row) + int'(cfg_row_off);
        if (col >= cfg_cols || row >= cfg_rows || acol >= NCOLS || arow >= NROWS)
            return -1;
        return arow * NCOLS + acol;
    endfunction

    function automatic lcd_result_t predict_lcd(input logic [39:0] d);
        lcd_result_t r;
        logic [15:0] gl;
        logic [7:0]  pr;
        logic [7:0]  fb;
        int n, cidx, old, got, start, p, least;
        logic [7:0] least_prio;
        bit found;
        r = '{default: '0};
        gl = d[23:8];
        pr = d[31:24];
        fb = d[39:32];
        n = (cfg_slots < NSLOTS) ? int'(cfg_slots) : NSLOTS;
        cidx = cell_index(d[5:1], d[7:6]);
        if (cidx < 0) begin
            r.ignored = 1'b1;
            return r;
        end
        if (d[0] == KindRead) begin
            r.cell_code = lcd_codes[cidx];
            return r;
        end
        old = lcd_codes[cidx];
        if (old < n && slot_refs[old] > 0)
            slot_refs[old]--;
        if (pr == 0) begin
            lcd_codes[cidx] = fb;
        end else begin
            got = -1;
            for (int s = 0; s < n; s++)
                if (got < 0 && slot_glyph_tbl[s] == gl)
                    got = s;
            if (got < 0 && n > 0) begin
                start = (rover < n) ? rover : 0;
                p = start;
                least = start;
                least_prio = slot_prio_tbl[start];
                found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!found) begin
                        p = (p + 1 >= n) ? 0 : p + 1;
                        if (slot_refs[p] == 0) begin
                            rover = p;
                            got = p;
                            found = 1'b1;
                        end else if (slot_prio_tbl[p] < least_prio) begin
                            least_prio = slot_prio_tbl[p];
                            least = p;
                        end
                    end
                end
                if (!found && pr > least_prio) begin
                    for (int c = 0; c < NCELLS; c++)
                        if (lcd_codes[c] == least)
                            lcd_codes[c] = lcd_fallbacks[c];
                    slot_refs[least] = 0;
                    rover = least;
                    r.slot_evicted = 1'b1;
                    got = least;
                end
                if (got >= 0) begin
                    slot_prio_tbl[got] = pr;
                    slot_glyph_tbl[got] = gl;
                    r.slot_defined = 1'b1;
                    r.slot_number = got[2:0];
                    r.slot_glyph = gl;
                end
            end
            if (got < 0) begin
                lcd_codes[cidx] = fb;
            end else begin
                if (slot_refs[got] < 8'd255)
                    slot_refs[got]++;
                lcd_fallbacks[cidx] = fb;
                fallback_known[cidx] = 1'b1;
                lcd_codes[cidx] = got[7:0];
            end
        end
        r.cell_code = lcd_codes[cidx];
        return r;
    endfunction

    task automatic push_item(input logic kind, input logic [4:0] col, input logic [1:0] row,
                             input logic [15:0] gl, input logic [7:0] pr,
                             input logic [7:0] fb);
        logic [39:0] d;
        int cidx;
        cidx = cell_index(col, row);
        // a slot-looking code with no stored fallback would make a later eviction undefined
        if (kind == KindWrite && cidx >= 0 && !fallback_known[cidx] && fb < NSLOTS)
            fb[3] = 1'b1;
        d = {fb, pr, gl, row, col, kind};
        expected_q.push_back(predict_lcd(d));
        item_q.push_back(d);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegColOffset: cfg_col_off = val[4:0];
            RegRowOffset: cfg_row_off = val[1:0];
            RegViewCols:  cfg_cols = val[5:0];
            RegViewRows:  cfg_rows = val[2:0];
            RegSlotsUsed: cfg_slots = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input int coff, input int roff, input int cols, input int rows,
                            input int slots);
        apb_write(RegColOffset, coff);
        apb_write(RegRowOffset, roff);
        apb_write(RegViewCols, cols);
        apb_write(RegViewRows, rows);
        apb_write(RegSlotsUsed, slots);
    endtask

    task automatic wait_drained();
        while (item_q.size() != 0 || expected_q.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(input int count);
        int maxc, maxr;
        logic [4:0] col;
        logic [1:0] row;
        logic [15:0] gl;
        logic [7:0] pr;
        for (int k = 0; k < count; k++) begin
            maxc = (int'(cfg_cols) < NCOLS - int'(cfg_col_off)) ? int'(cfg_cols)
                                                              : NCOLS - int'(cfg_col_off);
            maxr = (int'(cfg_rows) < NROWS - int'(cfg_row_off)) ? int'(cfg_rows)
                                                              : NROWS - int'(cfg_row_off);
            if ($urandom_range(0, 9) == 0) begin
                col = 5'($urandom);
                row = 2'($urandom);
            end else begin
                col = 5'($urandom_range(0, maxc - 1));
                row = 2'($urandom_range(0, maxr - 1));
            end
            // small glyph pool keeps reuse, eviction and fallback busy
            gl = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
            pr = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            push_item(($urandom_range(0, 3) == 0) ? KindRead : KindWrite, col, row, gl, pr,
                      8'($urandom));
        end
    endtask

    // sender: bursts and gaps
    logic s_fire = 1'b0;
    int   burst_left = 4;
    int   gap_left = 0;

    always @(posedge clk)
        s_fire <= s_tvalid && s_tready;

    always @(negedge clk) begin
        if (s_tvalid && !s_fire) begin
            // hold current transfer
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
            s_tdata <= item_q.pop_front();
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern is redrawn from three modes; one long hold-off
    bit long_hold = 1'b0;
    bit long_hold_used = 1'b0;
    int hold_left = 0;
    int stall_mode = 0;

    always @(negedge clk) begin
        if (cycle_count % 256 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (long_hold && !long_hold_used) begin
            long_hold_used <= 1'b1;
            hold_left <= 2000;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk) begin
        lcd_result_t exp_r;
        lcd_result_t got_r;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready) begin
            got_r.cell_code = m_tdata[7:0];
            got_r.slot_defined = m_tdata[8];
            got_r.slot_number = m_tdata[11:9];
            got_r.slot_glyph = m_tdata[27:12];
            got_r.slot_evicted = m_tdata[28];
            got_r.ignored = m_tdata[29];
            if (expected_q.size() == 0) begin
                err_count++;
                $display("%0t unexpected result transfer %h", $time, m_tdata);
            end else begin
                exp_r = expected_q.pop_front();
                if (got_r.cell_code !== exp_r.cell_code) begin
                    err_count++;
                    $display("%0t cell_code exp %h got %h", $time, exp_r.cell_code,
                             got_r.cell_code);
                end
                if (got_r.slot_defined !== exp_r.slot_defined) begin
                    err_count++;
                    $display("%0t slot_defined exp %b got %b", $time, exp_r.slot_defined,
                             got_r.slot_defined);
                end
                if (got_r.slot_number !== exp_r.slot_number) begin
                    err_count++;
                    $display("%0t slot_number exp %0d got %0d", $time, exp_r.slot_number,
                             got_r.slot_number);
                end
                if (got_r.slot_glyph !== exp_r.slot_glyph) begin
                    err_count++;
                    $display("%0t slot_glyph exp %h got %h", $time, exp_r.slot_glyph,
                             got_r.slot_glyph);
                end
                if (got_r.slot_evicted !== exp_r.slot_evicted) begin
                    err_count++;
                    $display("%0t slot_evicted exp %b got %b", $time, exp_r.slot_evicted,
                             got_r.slot_evicted);
                end
                if (got_r.ignored !== exp_r.ignored) begin
                    err_count++;
                    $display("%0t ignored exp %b got %b", $time, exp_r.ignored,
                             got_r.ignored);
                end
            end
        end
    end

    initial begin
        cfg_col_off = 0;
        cfg_row_off = 0;
        cfg_cols = 32;
        cfg_rows = 4;
        cfg_slots = 8;
        for (int c = 0; c < NCELLS; c++) begin
            lcd_codes[c] = CellResetCode;
            lcd_fallbacks[c] = '0;
            fallback_known[c] = 1'b0;
        end
        for (int s = 0; s < NSLOTS; s++) begin
            slot_glyph_tbl[s] = '0;
            slot_prio_tbl[s] = '0;
            slot_refs[s] = '0;
        end
        rover = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset defaults
        push_item(KindRead, 5'd0, 2'd0, 16'h0, 8'h0, 8'h0);
        push_item(KindWrite, 5'd31, 2'd3, 16'hffff, 8'd0, 8'hff);
        push_item(KindRead, 5'd31, 2'd3, 16'h0, 8'h0, 8'h0);
        // glyph 0 matches an idle slot after reset
        push_item(KindWrite, 5'd1, 2'd0, 16'h0000, 8'd5, 8'h41);
        push_item(KindWrite, 5'd2, 2'd0, 16'hffff, 8'd255, 8'h42);
        for (int g = 1; g <= 6; g++)
            push_item(KindWrite, 5'(g + 2), 2'd1, 16'(16'h100 + g), 8'(10 * g), 8'h43);
        // table full: low priority falls back, high priority evicts
        push_item(KindWrite, 5'd10, 2'd2, 16'h5555, 8'd1, 8'h7e);
        push_item(KindWrite, 5'd11, 2'd2, 16'haaaa, 8'd200, 8'h80);
        push_item(KindRead, 5'd1, 2'd0, 16'h0, 8'h0, 8'h0);
        // overwrite drops a reference, then the freed slot is found
        push_item(KindWrite, 5'd2, 2'd0, 16'h0, 8'd0, 8'h30);
        push_item(KindWrite, 5'd12, 2'd3, 16'h7777, 8'd3, 8'h31);
        push_item(KindRead, 5'd12, 2'd3, 16'h0, 8'h0, 8'h0);
        random_items(130);
        wait_drained();

        long_hold = 1'b1;
        set_view(31, 3, 1, 1, 1);
        push_item(KindRead, 5'd1, 2'd0, 16'h0, 8'h0, 8'h0);
        push_item(KindWrite, 5'd0, 2'd1, 16'h1, 8'd9, 8'h0);
        push_item(KindWrite, 5'd0, 2'd0, 16'h9, 8'd9, 8'h11);
        random_items(130);
        wait_drained();

        set_view(5, 1, 20, 3, 3);
        random_items(140);
        wait_drained();

        set_view(0, 0, 63, 7, 15);
        random_items(140);
        wait_drained();

        // no usable slots: every soft character falls back
        set_view(16, 2, 10, 2, 0);
        random_items(120);
        wait_drained();

        set_view(0, 0, 32, 4, 8);
        random_items(150);
        wait_drained();

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
